// ===== sv/spo_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// spo_pkg
// Types, register indexes, arithmetic constants and the shared Q15 rounding
// helper for the sine pattern oscillator.
// -----------------------------------------------------------------------------
package spo_pkg;

	// item opcodes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_CONTROL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CONNECTION_COUNT = 3'd5;

	localparam logic [15:0] MAX_FREQ_RST  = 16'd256;
	localparam logic [15:0] TIME_STEP_RST = 16'd3277;

	// 2^32 / (256*pi), split over two products
	localparam logic [22:0] INC_SCALE = 23'd5340354;
	// sine polynomial coefficients, Q1.30
	localparam logic [30:0] COEF_A  = 31'd1686629713;
	localparam logic [30:0] COEF_B  = 31'd688904866;
	localparam logic [30:0] COEF_C  = 31'd76016977;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	typedef struct packed {
		logic              opcode;
		logic [2:0]        target_index;
		logic signed [15:0] weight_value;
	} spo_in_t;

	typedef struct packed {
		logic signed [15:0] neuron_out;
		logic [2:0]        conn_index;
		logic signed [15:0] weighted_out;
		logic              conn_valid;
		logic              last;
	} spo_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZZ,
		ST_ZC,
		ST_F1,
		ST_ZR,
		ST_F2,
		ST_ZS,
		ST_HI,
		ST_LO,
		ST_AMP,
		ST_ACC,
		ST_RD,
		ST_WM,
		ST_OUT
	} spo_state_t;

	// floor((v + 2^14) / 2^15), saturated to 16 bits signed
	function automatic logic signed [15:0] rnd_sat(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] sh;
		logic signed [15:0] r;
		t  = {v[32], v} + 34'sd16384;
		sh = t[33:15];
		if (sh > 19'sd32767)
			r = 16'sh7fff;
		else if (sh < -19'sd32768)
			r = 16'sh8000;
		else
			r = sh[15:0];
		return r;
	endfunction

endpackage

// ===== sv/sine_pattern_oscillator_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sine_pattern_oscillator_unit
// Phase-accumulator sine oscillator with weighted fan-out to up to
// MAX_CONNECTIONS connections.
// -----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid / in_stall / in_data): opcode 0 is a tick, opcode 1
//   writes a Q1.15 weight into the weight table (no result).
//   out channel (out_valid / out_stall / out_data): one item per connection in
//   use, last set on the final one; with no connections a single item with
//   conn_valid low.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready,
//   write only while the block is idle.
// Sequencing: a tick holds in_stall high until its last result is loaded into
//   the output register, including any time the output is stalled.
//   The sine polynomial and the phase increment share one 32x32 multiplier
//   over the sequencer steps ST_ZZ to ST_LO; each connection then takes a
//   weight read, a multiply and an output load. The first result is loaded
//   in ST_OUT, reached from ST_ACC with no connections or via ST_RD and ST_WM.
// Reset clears the phase accumulator, the weight table and the registers to
//   their defaults. A result held under out_stall stays put; the block takes
//   the next item while the last result still waits.
// -----------------------------------------------------------------------------
module sine_pattern_oscillator_unit #(
	parameter int unsigned MAX_CONNECTIONS = 8,
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  spo_pkg::spo_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output spo_pkg::spo_out_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                         cfg_data
);

	localparam int unsigned AW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
	localparam int unsigned CW = $clog2(MAX_CONNECTIONS + 1);
	localparam int unsigned EW = (CW > 4) ? CW : 4;
	localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);

	// configuration
	logic signed [15:0] fc_q, amp_q;
	logic [15:0]        po_q, mf_q, ts_q;
	logic [3:0]         cc_q;

	// control
	spo_pkg::spo_state_t state_q, state_d;
	logic [31:0]        acc_q;
	logic [CW-1:0]      k_q, n_q;
	logic               out_valid_q;
	spo_pkg::spo_out_t  out_q, out_d;
	logic               out_free, out_load, last_k, n_zero;

	// datapath
	logic [30:0]        z_q, z2_q, r_q;
	logic [1:0]         quad_q;
	logic [15:0]        fcmag_q, smag_q;
	logic               incneg_q;
	logic [31:0]        fm_q, inc_q;
	logic [47:0]        mag_q;
	logic [46:0]        hi_q;
	logic signed [16:0] sn_q;
	logic signed [32:0] yprod_q;
	logic signed [15:0] y_q;
	logic signed [31:0] wprod_q;
	logic [63:0]        prod_q;
	logic [31:0]        mul_a, mul_b;

	// angle fold on tick accept
	logic [31:0]        angle, q_ang;
	logic [30:0]        zraw;
	logic [EW-1:0]      cc_ext, n_sel;
	logic [32:0]        s_sum;
	logic [17:0]        s_rnd;
	logic [47:0]        inc_sum;

	// weight memory
	logic               tick_acc, wr_en, rd_en;
	logic [AW+2:0]      tgt_ext;
	logic signed [15:0] w_rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != spo_pkg::ST_IDLE);
	assign tick_acc  = in_valid && !in_stall && (in_data.opcode == spo_pkg::OP_TICK);
	assign tgt_ext   = (AW + 3)'(in_data.target_index);
	assign wr_en     = in_valid && !in_stall && (in_data.opcode == spo_pkg::OP_WEIGHT)
		&& (tgt_ext < (AW + 3)'(MAX_CONNECTIONS));
	assign rd_en     = (state_q == spo_pkg::ST_RD);

	spo_weight_mem #(
		.DEPTH (MAX_CONNECTIONS),
		.AW    (AW)
	) u_wmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (tgt_ext[AW-1:0]),
		.wr_data (in_data.weight_value),
		.rd_en   (rd_en),
		.rd_addr (k_q[AW-1:0]),
		.rd_data (w_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= '0;
			amp_q <= '0;
			po_q  <= '0;
			mf_q  <= spo_pkg::MAX_FREQ_RST;
			ts_q  <= spo_pkg::TIME_STEP_RST;
			cc_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spo_pkg::CFG_FREQ_CONTROL:     fc_q  <= cfg_data;
				spo_pkg::CFG_AMPLITUDE:        amp_q <= cfg_data;
				spo_pkg::CFG_PHASE_OFFSET:     po_q  <= cfg_data;
				spo_pkg::CFG_MAX_FREQ:         mf_q  <= cfg_data;
				spo_pkg::CFG_TIME_STEP:        ts_q  <= cfg_data;
				spo_pkg::CFG_CONNECTION_COUNT: cc_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// angle and connection count at tick accept
	assign angle  = acc_q + {po_q, 16'h0000};
	assign q_ang  = angle & ANG_MASK;
	assign zraw   = {1'b0, q_ang[29:0]};
	assign cc_ext = EW'(cc_q);
	assign n_sel  = (cc_ext > EW'(MAX_CONNECTIONS)) ? EW'(MAX_CONNECTIONS) : cc_ext;

	// shared unsigned multiplier, operands by sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			spo_pkg::ST_ZZ: begin
				mul_a = 32'(z_q);
				mul_b = 32'(z_q);
			end
			spo_pkg::ST_ZC: begin
				mul_a = prod_q[61:30];
				mul_b = 32'(spo_pkg::COEF_C);
			end
			spo_pkg::ST_F1: begin
				mul_a = 32'(fcmag_q);
				mul_b = 32'(mf_q);
			end
			spo_pkg::ST_ZR: begin
				mul_a = 32'(z2_q);
				mul_b = 32'(r_q);
			end
			spo_pkg::ST_F2: begin
				mul_a = fm_q;
				mul_b = 32'(ts_q);
			end
			spo_pkg::ST_ZS: begin
				mul_a = 32'(z_q);
				mul_b = 32'(r_q);
			end
			spo_pkg::ST_HI: begin
				mul_a = 32'(mag_q[47:24]);
				mul_b = 32'(spo_pkg::INC_SCALE);
			end
			spo_pkg::ST_LO: begin
				mul_a = 32'(mag_q[23:0]);
				mul_b = 32'(spo_pkg::INC_SCALE);
			end
			default: ;
		endcase
	end

	assign s_sum   = {1'b0, prod_q[61:30]} + 33'd16384;
	assign s_rnd   = s_sum[32:15];
	assign inc_sum = {1'b0, hi_q} + 48'(prod_q[46:24]);

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (tick_acc) begin
			quad_q   <= q_ang[31:30];
			z_q      <= q_ang[30] ? (spo_pkg::ONE_Q30 - zraw) : zraw;
			fcmag_q  <= fc_q[15] ? 16'(-fc_q) : 16'(fc_q);
			incneg_q <= fc_q[15];
			n_q      <= CW'(n_sel);
		end
		case (state_q)
			spo_pkg::ST_ZC:  z2_q   <= prod_q[60:30];
			spo_pkg::ST_F1:  r_q    <= spo_pkg::COEF_B - prod_q[60:30];
			spo_pkg::ST_ZR:  fm_q   <= prod_q[31:0];
			spo_pkg::ST_F2:  r_q    <= spo_pkg::COEF_A - prod_q[60:30];
			spo_pkg::ST_ZS:  mag_q  <= prod_q[47:0];
			spo_pkg::ST_HI:  smag_q <= (s_rnd > 18'd32768) ? 16'h8000 : s_rnd[15:0];
			spo_pkg::ST_LO: begin
				hi_q <= prod_q[46:0];
				sn_q <= quad_q[1] ? -{1'b0, smag_q} : {1'b0, smag_q};
			end
			spo_pkg::ST_AMP: begin
				inc_q   <= inc_sum[39:8];
				yprod_q <= 33'(amp_q) * 33'(sn_q);
			end
			spo_pkg::ST_ACC: y_q     <= spo_pkg::rnd_sat(yprod_q);
			spo_pkg::ST_WM:  wprod_q <= 32'(y_q) * 32'(w_rdata);
			default: ;
		endcase
	end

	// phase accumulator and connection counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			k_q   <= '0;
		end else begin
			if (state_q == spo_pkg::ST_ACC) begin
				acc_q <= incneg_q ? (acc_q - inc_q) : (acc_q + inc_q);
				k_q   <= '0;
			end else if (out_load && !last_k) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	assign n_zero   = (n_q == '0);
	assign last_k   = ((CW + 1)'(k_q) + (CW + 1)'(1)) == (CW + 1)'(n_q);
	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= spo_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_d.neuron_out   = y_q;
		out_d.conn_index   = n_zero ? 3'd0 : 3'(k_q);
		out_d.weighted_out = n_zero ? 16'sd0 : spo_pkg::rnd_sat(33'(wprod_q));
		out_d.conn_valid   = !n_zero;
		out_d.last         = n_zero || last_k;
		unique case (state_q)
			spo_pkg::ST_IDLE: if (tick_acc) state_d = spo_pkg::ST_ZZ;
			spo_pkg::ST_ZZ:   state_d = spo_pkg::ST_ZC;
			spo_pkg::ST_ZC:   state_d = spo_pkg::ST_F1;
			spo_pkg::ST_F1:   state_d = spo_pkg::ST_ZR;
			spo_pkg::ST_ZR:   state_d = spo_pkg::ST_F2;
			spo_pkg::ST_F2:   state_d = spo_pkg::ST_ZS;
			spo_pkg::ST_ZS:   state_d = spo_pkg::ST_HI;
			spo_pkg::ST_HI:   state_d = spo_pkg::ST_LO;
			spo_pkg::ST_LO:   state_d = spo_pkg::ST_AMP;
			spo_pkg::ST_AMP:  state_d = spo_pkg::ST_ACC;
			spo_pkg::ST_ACC:  state_d = n_zero ? spo_pkg::ST_OUT : spo_pkg::ST_RD;
			spo_pkg::ST_RD:   state_d = spo_pkg::ST_WM;
			spo_pkg::ST_WM:   state_d = spo_pkg::ST_OUT;
			spo_pkg::ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = (n_zero || last_k) ? spo_pkg::ST_IDLE : spo_pkg::ST_RD;
				end
			end
			default: state_d = spo_pkg::ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_wr_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == spo_pkg::ST_IDLE))
		else $error("weight write outside idle");

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> (state_q == spo_pkg::ST_ZZ))
		else $error("tick did not start the sequencer");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == spo_pkg::ST_RD || state_q == spo_pkg::ST_WM ||
		  state_q == spo_pkg::ST_OUT) && !n_zero) |-> (k_q < n_q))
		else $error("connection counter past count");

	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spo_pkg::ST_AMP) |-> (sn_q <= 17'sd32768 && sn_q >= -17'sd32768))
		else $error("sine out of Q1.15 range");
`endif

endmodule

// ===== sv/spo_weight_mem.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// spo_weight_mem
// Connection weight store: one write port, one registered read port. A per
// entry valid bit makes never-written entries read as zero after reset.
// -----------------------------------------------------------------------------
module spo_weight_mem #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic signed [15:0]  wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic signed [15:0]  rd_data
);

	logic signed [15:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic signed [15:0] rdata_q;
	logic               rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rvld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign rd_data = rvld_q ? rdata_q : 16'sd0;

endmodule
